// File: design/ftd_pkg.sv
// Shared types and constants for the truncating divider.
`timescale 1ns / 1ps
package ftd_pkg;
    localparam int MantW = 24;
    localparam int DivStages = 5;
    localparam int StepsPerStage = 5;
    // Bit 39 of the quotient from the unpack compare, then bits 38 down to 14.
    localparam int QuotW = DivStages * StepsPerStage + 1;
    localparam int ExpW = 10;
    localparam int RemW = 25;
    localparam logic [1:0] FLAG_OK = 2'd0;
    localparam logic [1:0] FLAG_OVF = 2'd1;
    localparam logic [1:0] FLAG_UNF = 2'd2;

    typedef struct packed {
        logic              sign;
        logic [ExpW-1:0]   exp;
        logic [RemW-1:0]   rem;
        logic [MantW-1:0]  divisor;
        logic [QuotW-1:0]  quot;
    } div_state_t;
endpackage

// File: design/ftd_div_stage.sv
// One pipeline stage holding a few restoring-division steps.
`timescale 1ns / 1ps
module ftd_div_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  ftd_pkg::div_state_t in_state,
    output logic               out_valid,
    output ftd_pkg::div_state_t out_state
);
    logic valid_reg;
    ftd_pkg::div_state_t state_reg;
    ftd_pkg::div_state_t state_next;

    // Five shift-subtract quotient bits.
    always_comb begin
        logic [ftd_pkg::RemW:0] trial;
        state_next = in_state;
        for (int i = 0; i < ftd_pkg::StepsPerStage; i++) begin
            trial = {state_next.rem, 1'b0} - {2'b00, state_next.divisor};
            if (!trial[ftd_pkg::RemW]) begin
                state_next.rem = trial[ftd_pkg::RemW-1:0];
                state_next.quot = {state_next.quot[ftd_pkg::QuotW-2:0], 1'b1};
            end else begin
                state_next.rem = {state_next.rem[ftd_pkg::RemW-2:0], 1'b0};
                state_next.quot = {state_next.quot[ftd_pkg::QuotW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
endmodule

// File: design/fp32_truncating_divide.sv
// Top level of the pipelined single-precision truncating divider.
//   channel  | dir | tdata fields (low bit up)
//   s_axis   | in  | dividend_bits[31:0], divisor_bits[63:32]
//   m_axis   | out | quotient_bits[31:0], range_flag[33:32], zeros to bit 39
// A result passes through one unpack register, five division stages of five
// quotient bits each, and the output register.
// One item is accepted per cycle; a stall on m_axis freezes the whole pipeline.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module fp32_truncating_divide (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // dividend_bits, divisor_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // quotient_bits, range_flag, zero pad
);
    logic advance;
    logic v0_reg;
    ftd_pkg::div_state_t s0_reg, s0_next;
    logic [ftd_pkg::DivStages:0] v;
    ftd_pkg::div_state_t st [ftd_pkg::DivStages+1];
    logic out_valid_reg;
    logic [39:0] out_data_reg, out_data_next;

    assign advance = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    // Unpack: first quotient bit is mantissa_a >= mantissa_b; remainder starts as mantissa_a, less mantissa_b if so.
    always_comb begin
        logic [31:0] a, b;
        logic [23:0] ma, mb;
        a = s_axis_tdata[31:0];
        b = s_axis_tdata[63:32];
        ma = {1'b1, a[22:0]};
        mb = {1'b1, b[22:0]};
        s0_next.sign = a[31] ^ b[31];
        s0_next.exp = {2'b00, a[30:23]} - {2'b00, b[30:23]} + 10'd127;
        s0_next.divisor = mb;
        if (ma >= mb) begin
            s0_next.rem = {1'b0, ma - mb};
            s0_next.quot = {{(ftd_pkg::QuotW-1){1'b0}}, 1'b1};
        end else begin
            s0_next.rem = {1'b0, ma};
            s0_next.quot = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (advance) begin
            v0_reg <= s_axis_tvalid;
        end
        if (advance) begin
            s0_reg <= s0_next;
        end
    end

    assign v[0] = v0_reg;
    assign st[0] = s0_reg;

    for (genvar g = 0; g < ftd_pkg::DivStages; g++) begin : g_div
        ftd_div_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_valid (v[g]),
            .in_state (st[g]),
            .out_valid(v[g+1]),
            .out_state(st[g+1])
        );
    end

    // Pack: normalize, adjust exponent, range check.
    always_comb begin
        ftd_pkg::div_state_t f;
        logic [9:0] e;
        logic [22:0] frac;
        logic [31:0] res;
        logic [1:0] flag;
        f = st[ftd_pkg::DivStages];
        if (f.quot[25]) begin
            e = f.exp;
            frac = f.quot[24:2];
        end else begin
            e = f.exp - 10'd1;
            frac = f.quot[23:1];
        end
        if (!e[9] && e[8:0] > 9'd254) begin
            res = {f.sign, 8'hFF, 23'd0};
            flag = ftd_pkg::FLAG_OVF;
        end else if (e[9] || e == 10'd0) begin
            res = {f.sign, 31'd0};
            flag = ftd_pkg::FLAG_UNF;
        end else begin
            res = {f.sign, e[7:0], frac};
            flag = ftd_pkg::FLAG_OK;
        end
        out_data_next = {6'd0, flag, res};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= v[ftd_pkg::DivStages];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
endmodule

// File: design/ftd_checker.sv
// Port-level checker for the truncating divider, bound to the top level.
`timescale 1ns / 1ps
module ftd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // The flag never reads three.
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
        else $error("bad range flag");
    // Overflow gives infinity, underflow zero.
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[33:32] == 2'd1 |-> m_axis_tdata[30:0] == 31'h7F800000)
        else $error("overflow not infinity");
    a_unf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[33:32] == 2'd2 |-> m_axis_tdata[30:0] == 31'd0)
        else $error("underflow not zero");
    // Input is ready whenever no result is presented.
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked without stall");
endmodule

bind fp32_truncating_divide ftd_checker u_ftd_checker (.*);

// File: bench/fp32_truncating_divide_checker.sv
// Checker that predicts and compares quotients of the truncating divider.
`timescale 1ns / 1ps
module fp32_truncating_divide_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    output int          error_count,
    output int          pending_count
);
    typedef struct packed {
        logic [31:0] quotient;
        logic [1:0]  flag;
    } quotient_t;

    quotient_t expected_quotients[$];

    // Truncated quotient of two single-precision patterns.
    function automatic quotient_t divide_truncated(logic [31:0] a, logic [31:0] b);
        quotient_t   r;
        logic        sgn;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [63:0] mant;
        int          e;
        sgn = a[31] ^ b[31];
        ma = {40'd0, 1'b1, a[22:0]};
        mb = {40'd0, 1'b1, b[22:0]};
        q = (ma << 39) / mb;
        e = int'(a[30:23]) - int'(b[30:23]) + 127;
        if (ma < mb) begin
            mant = q >> 15;
            e = e - 1;
        end else begin
            mant = q >> 16;
        end
        if (e > 254) begin
            r.quotient = {sgn, 8'hFF, 23'd0};
            r.flag = ftd_pkg::FLAG_OVF;
        end else if (e < 1) begin
            r.quotient = {sgn, 31'd0};
            r.flag = ftd_pkg::FLAG_UNF;
        end else begin
            r.quotient = {sgn, e[7:0], mant[22:0]};
            r.flag = ftd_pkg::FLAG_OK;
        end
        return r;
    endfunction

    assign pending_count = expected_quotients.size();

    // Predict on each accepted input item, compare on each accepted result item.
    always @(posedge aclk) begin
        quotient_t want;
        if (!aresetn) begin
            error_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_quotients.push_back(
                    divide_truncated(s_axis_tdata[31:0], s_axis_tdata[63:32]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_quotients.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, m_axis_tdata);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_quotients.pop_front();
                    if (m_axis_tdata[31:0] !== want.quotient
                            || m_axis_tdata[33:32] !== want.flag
                            || m_axis_tdata[39:34] !== 6'd0) begin
                        $display("%0t: expected quotient %h flag %0d, actual %h flag %0d pad %h",
                                 $time, want.quotient, want.flag, m_axis_tdata[31:0],
                                 m_axis_tdata[33:32], m_axis_tdata[39:34]);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: bench/tb_fp32_truncating_divide.sv
// Testbench top for the truncating divider: stimulus, reset and verdict.
`timescale 1ns / 1ps
module tb_fp32_truncating_divide;
    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    int          error_count;
    int          pending_count;
    int          cycle_count = 0;
    int          sink_wait;

    fp32_truncating_divide u_dut (.*);

    fp32_truncating_divide_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit: generous multiple of the slowest legal run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stall length before each accepted item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_wait <= 0;
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            m_axis_tready <= (sink_wait == 1);
        end else if (m_axis_tvalid && m_axis_tready) begin
            sink_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            m_axis_tready <= (cycle_count > 20000 && cycle_count < 24000);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Random float pattern biased toward edge exponents and mantissas.
    function automatic logic [31:0] pick_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'($urandom_range(0, 3));
            1: v[30:23] = 8'($urandom_range(252, 255));
            2: v[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
            default: ;
        endcase
        return v;
    endfunction

    // Present one item, wait for acceptance, then an optional gap.
    task automatic send_item(logic [31:0] a, logic [31:0] b, int gap);
        s_axis_tdata <= {b, a};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        logic [31:0] edge_vals[10];
        int idx;
        edge_vals = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FFFFFFF,
                      32'h3F800000, 32'h3FFFFFFF, 32'h00800000, 32'h7F7FFFFF, 32'hFFFFFFFF};
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: zero, infinity, NaN, extremes, overflow and underflow.
        for (idx = 0; idx < 24; idx++)
            send_item(edge_vals[idx % 10], edge_vals[(idx * 3 + 1) % 10], 0);
        send_item(32'h7F000000, 32'h00000000, 1);
        // Random items with random gaps, runs of back-to-back items mixed in, and a drain at item 700.
        for (idx = 0; idx < 1550; idx++) begin
            if (idx == 700) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_count != 0) @(posedge aclk);
            end
            send_item(pick_float(), pick_float(),
                      (idx % 200 < 60) ? 0 : $urandom_range(0, 16));
        end
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: files.f
design/ftd_pkg.sv
design/ftd_div_stage.sv
design/fp32_truncating_divide.sv
design/ftd_checker.sv
bench/fp32_truncating_divide_checker.sv
bench/tb_fp32_truncating_divide.sv
